FILE: rtl/pabr_pkg.sv
package pabr_pkg;

	// Default geometry of the block
	localparam int DEF_MAX_VERTICES = 1024;
	localparam int DEF_COORD_BITS   = 16;

	// Fixed result field widths
	localparam int AREA_W  = 44;
	localparam int INDEX_W = 10;
	localparam int TOTAL_W = 11;

	// Control that travels with a vertex between the front end and the accumulator
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} pabr_ctl_t;

endpackage

FILE: rtl/pabr_front.sv
module pabr_front
	import pabr_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vertex_valid,
	output logic                         vertex_stall,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic                         is_last,
	input  logic                         take_s2,
	output pabr_ctl_t                    ctl_s2,
	output logic signed [COORD_BITS-1:0] cur_x_s2,
	output logic signed [COORD_BITS-1:0] cur_y_s2,
	output logic signed [AREA_W-1:0]     edge_term_s2,
	output logic signed [AREA_W-1:0]     close_term_s2
);

	localparam int SUM_W  = COORD_BITS + 1;
	localparam int PROD_W = 2 * SUM_W;

	logic                         start_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, first_x_q, first_y_q;

	logic                         valid_s1, first_s1, last_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, px_s1, py_s1, fx_s1, fy_s1;

	logic                         valid_s2, first_s2, last_s2;

	logic                         accept, move_s12;
	logic signed [SUM_W-1:0]      edge_sx, edge_dy, close_sx, close_dy;
	logic signed [PROD_W-1:0]     edge_prod, close_prod;

	// Handshake: stage one empties into stage two when that one is free or drains
	assign move_s12     = valid_s1 && (!valid_s2 || take_s2);
	assign vertex_stall = valid_s1 && !move_s12;
	assign accept       = vertex_valid && !vertex_stall;

	// Track ring start, previous and first vertex at the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= 1'b1;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
		end else if (accept) begin
			start_q  <= is_last;
			prev_x_q <= x_coord;
			prev_y_q <= y_coord;
			if (start_q) begin
				first_x_q <= x_coord;
				first_y_q <= y_coord;
			end
		end
	end

	// Stage one: register the beat with its neighbors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s12) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= x_coord;
			y_s1     <= y_coord;
			px_s1    <= prev_x_q;
			py_s1    <= prev_y_q;
			fx_s1    <= start_q ? x_coord : first_x_q;
			fy_s1    <= start_q ? y_coord : first_y_q;
			first_s1 <= start_q;
			last_s1  <= is_last;
		end
	end

	// Shoelace products for the incoming edge and the closing edge
	assign edge_sx    = SUM_W'(px_s1) + SUM_W'(x_s1);
	assign edge_dy    = SUM_W'(y_s1) - SUM_W'(py_s1);
	assign close_sx   = SUM_W'(x_s1) + SUM_W'(fx_s1);
	assign close_dy   = SUM_W'(fy_s1) - SUM_W'(y_s1);
	assign edge_prod  = PROD_W'(edge_sx) * PROD_W'(edge_dy);
	assign close_prod = PROD_W'(close_sx) * PROD_W'(close_dy);

	// Stage two: hold the products for the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s12) begin
			valid_s2 <= 1'b1;
		end else if (take_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s12) begin
			first_s2      <= first_s1;
			last_s2       <= last_s1;
			cur_x_s2      <= x_s1;
			cur_y_s2      <= y_s1;
			edge_term_s2  <= first_s1 ? '0 : AREA_W'(edge_prod);
			close_term_s2 <= AREA_W'(close_prod);
		end
	end

	assign ctl_s2 = '{valid: valid_s2, first: first_s2, last: last_s2};

endmodule

FILE: rtl/pabr_accum.sv
module pabr_accum
	import pabr_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int COORD_BITS   = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pabr_ctl_t                    ctl_s2,
	input  logic signed [COORD_BITS-1:0] cur_x_s2,
	input  logic signed [COORD_BITS-1:0] cur_y_s2,
	input  logic signed [AREA_W-1:0]     edge_term_s2,
	input  logic signed [AREA_W-1:0]     close_term_s2,
	output logic                         take_s2,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [AREA_W-1:0]     area_doubled,
	output logic                         is_ccw,
	output logic signed [COORD_BITS-1:0] box_min_x,
	output logic signed [COORD_BITS-1:0] box_min_y,
	output logic signed [COORD_BITS-1:0] box_max_x,
	output logic signed [COORD_BITS-1:0] box_max_y,
	output logic [INDEX_W-1:0]           hull_index,
	output logic [TOTAL_W-1:0]           vertex_total,
	output logic                         too_many
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	logic signed [AREA_W-1:0]     area_q;
	logic signed [COORD_BITS-1:0] min_x_q, min_y_q, max_x_q, max_y_q, best_x_q, best_y_q;
	logic [INDEX_W-1:0]           best_idx_q;
	logic [CNT_W-1:0]             count_q;
	logic                         over_q;

	logic signed [AREA_W-1:0]     area_run, area_fin;
	logic signed [COORD_BITS-1:0] min_x_nx, min_y_nx, max_x_nx, max_y_nx, best_x_nx, best_y_nx;
	logic [INDEX_W-1:0]           best_idx_nx;
	logic [CNT_W-1:0]             count_nx;
	logic                         over_nx, room, better, emit;

	// A non-final beat never waits on the result register
	assign take_s2 = ctl_s2.valid && (!ctl_s2.last || !result_valid || !result_stall);
	assign emit    = take_s2 && ctl_s2.last;

	// Next accumulator values for this vertex
	always_comb begin
		room     = count_q < CNT_W'(MAX_VERTICES);
		better   = (cur_x_s2 < best_x_q) || ((cur_x_s2 == best_x_q) && (cur_y_s2 < best_y_q));
		area_run = (ctl_s2.first ? '0 : area_q) + edge_term_s2;
		area_fin = area_run + close_term_s2;
		if (ctl_s2.first) begin
			min_x_nx    = cur_x_s2;
			min_y_nx    = cur_y_s2;
			max_x_nx    = cur_x_s2;
			max_y_nx    = cur_y_s2;
			best_x_nx   = cur_x_s2;
			best_y_nx   = cur_y_s2;
			best_idx_nx = '0;
		end else begin
			min_x_nx    = (cur_x_s2 < min_x_q) ? cur_x_s2 : min_x_q;
			min_y_nx    = (cur_y_s2 < min_y_q) ? cur_y_s2 : min_y_q;
			max_x_nx    = (cur_x_s2 > max_x_q) ? cur_x_s2 : max_x_q;
			max_y_nx    = (cur_y_s2 > max_y_q) ? cur_y_s2 : max_y_q;
			best_x_nx   = best_x_q;
			best_y_nx   = best_y_q;
			best_idx_nx = best_idx_q;
			if (room && better) begin
				best_x_nx   = cur_x_s2;
				best_y_nx   = cur_y_s2;
				best_idx_nx = INDEX_W'(count_q);
			end
		end
		count_nx = room ? count_q + 1'b1 : count_q;
		over_nx  = over_q || !room;
	end

	// Advance the running sums; clear count and overflow at the end of a ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			over_q  <= 1'b0;
		end else if (take_s2) begin
			count_q <= ctl_s2.last ? '0 : count_nx;
			over_q  <= ctl_s2.last ? 1'b0 : over_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2) begin
			area_q     <= area_run;
			min_x_q    <= min_x_nx;
			min_y_q    <= min_y_nx;
			max_x_q    <= max_x_nx;
			max_y_q    <= max_y_nx;
			best_x_q   <= best_x_nx;
			best_y_q   <= best_y_nx;
			best_idx_q <= best_idx_nx;
		end
	end

	// Result register: load on the last vertex, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			area_doubled <= area_fin;
			is_ccw       <= !area_fin[AREA_W-1] && (area_fin != '0);
			box_min_x    <= min_x_nx;
			box_min_y    <= min_y_nx;
			box_max_x    <= max_x_nx;
			box_max_y    <= max_y_nx;
			hull_index   <= best_idx_nx;
			vertex_total <= TOTAL_W'(count_nx);
			too_many     <= over_nx;
		end
	end

endmodule

FILE: rtl/polygon_area_bbox_reduce_core.sv
// Shoelace area and bounding box of one closed polygon.
// Input channel (vertex_valid / vertex_stall): one vertex per beat in ring
// order, signed x_coord and y_coord, is_last high on the final vertex.
// Output channel (result_valid / result_stall): one beat per ring carrying
// the doubled signed area, its orientation, the bounding box, the index of
// the leftmost-then-lowest vertex, the vertex count and the overflow flag.
// Throughput: one vertex per cycle while the input is not stalled; a beat of a
// new ring may follow the last beat of the previous ring in the next cycle.
// After the last vertex is accepted, the result beat passes through the input
// register, the product register and the result register.
// The two multipliers of the product stage set the cycle time.
// Reset clears all valid flags and starts a fresh ring.
// When the receiver stalls, the result is held; vertices that do not end a
// ring keep flowing, and the input stalls only when a second finished ring
// reaches the full result register.
module polygon_area_bbox_reduce_core
	import pabr_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int COORD_BITS   = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vertex_valid,
	output logic                         vertex_stall,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic                         is_last,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [AREA_W-1:0]     area_doubled,
	output logic                         is_ccw,
	output logic signed [COORD_BITS-1:0] box_min_x,
	output logic signed [COORD_BITS-1:0] box_min_y,
	output logic signed [COORD_BITS-1:0] box_max_x,
	output logic signed [COORD_BITS-1:0] box_max_y,
	output logic [INDEX_W-1:0]           hull_index,
	output logic [TOTAL_W-1:0]           vertex_total,
	output logic                         too_many
);

	pabr_ctl_t                    ctl_s2;
	logic                         take_s2;
	logic signed [COORD_BITS-1:0] cur_x_s2, cur_y_s2;
	logic signed [AREA_W-1:0]     edge_term_s2, close_term_s2;

	// Input register and edge products
	pabr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.is_last      (is_last),
		.take_s2      (take_s2),
		.ctl_s2       (ctl_s2),
		.cur_x_s2     (cur_x_s2),
		.cur_y_s2     (cur_y_s2),
		.edge_term_s2 (edge_term_s2),
		.close_term_s2(close_term_s2)
	);

	// Running sums, box, hull vertex and result register
	pabr_accum #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s2       (ctl_s2),
		.cur_x_s2     (cur_x_s2),
		.cur_y_s2     (cur_y_s2),
		.edge_term_s2 (edge_term_s2),
		.close_term_s2(close_term_s2),
		.take_s2      (take_s2),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.area_doubled (area_doubled),
		.is_ccw       (is_ccw),
		.box_min_x    (box_min_x),
		.box_min_y    (box_min_y),
		.box_max_x    (box_max_x),
		.box_max_y    (box_max_y),
		.hull_index   (hull_index),
		.vertex_total (vertex_total),
		.too_many     (too_many)
	);

endmodule
